FILE: hdl/stt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the software timer table.
package stt_pkg;

    localparam int TIME_WIDTH = 32;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [TIME_WIDTH-1:0] MIN_TIMEOUT = 32'd1;

    // Operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_IDLE,
        OP_ADD,
        OP_TICK,
        OP_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic [TIME_WIDTH-1:0]   value;
    } cell_ctl_t;

    // What the cell holding the token did this cycle
    typedef struct packed {
        logic stop;
        logic fire;
        logic append;
    } cell_stat_t;

endpackage

FILE: hdl/stt_cell.sv
`timescale 1ns / 1ps
// One timer slot of the table: key, remaining time and the walking token.
module stt_cell
    import stt_pkg::*;
#(
    parameter int KEY_WIDTH = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctl_t             ctl,
    input  logic [KEY_WIDTH-1:0]  key_cmd,
    input  logic                  occupied,
    input  logic                  tok_in,
    input  logic [KEY_WIDTH-1:0]  nb_key,
    input  logic [TIME_WIDTH-1:0] nb_rem,
    output logic                  tok_out,
    output logic                  tok_q,
    output cell_stat_t            stat,
    output logic [KEY_WIDTH-1:0]  key_q,
    output logic [TIME_WIDTH-1:0] rem_q
);

    logic [KEY_WIDTH-1:0]  key_reg, key_next;
    logic [TIME_WIDTH-1:0] rem_reg, rem_next;
    logic                  tok_reg, tok_next;
    logic                  pass;
    logic                  hold;
    logic                  expired;
    logic [TIME_WIDTH-1:0] rem_dec;

    // saturating decrement
    assign expired = (rem_reg <= ctl.value);
    assign rem_dec = expired ? '0 : (rem_reg - ctl.value);

    always_comb
    begin
        key_next = key_reg;
        rem_next = rem_reg;
        pass     = 1'b0;
        hold     = 1'b0;
        stat     = '0;
        if (tok_reg)
        begin
            unique case (ctl.op)
                OP_ADD:
                begin
                    if (!occupied)
                    begin
                        key_next    = key_cmd;
                        rem_next    = ctl.value;
                        stat.stop   = 1'b1;
                        stat.append = 1'b1;
                    end
                    else if (key_reg == key_cmd)
                    begin
                        rem_next  = ctl.value;
                        stat.stop = 1'b1;
                    end
                    else
                    begin
                        pass = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (!occupied)
                    begin
                        stat.stop = 1'b1;
                    end
                    else
                    begin
                        rem_next = rem_dec;
                        if (expired)
                        begin
                            // keep the token here to start compaction
                            stat.stop = 1'b1;
                            stat.fire = 1'b1;
                            hold      = 1'b1;
                        end
                        else
                        begin
                            pass = 1'b1;
                        end
                    end
                end
                OP_SHIFT:
                begin
                    if (occupied)
                    begin
                        key_next = nb_key;
                        rem_next = nb_rem;
                        pass     = 1'b1;
                    end
                    else
                    begin
                        stat.stop = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign tok_next = tok_in | (tok_reg & hold);
    assign tok_out  = tok_reg & pass;
    assign tok_q    = tok_reg;
    assign key_q    = key_reg;
    assign rem_q    = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        rem_reg <= rem_next;
    end

endmodule

FILE: hdl/software_timer_table.sv
`timescale 1ns / 1ps
// Top level of the software timer table: command sequencer and the row of timer cells.
//
// The table holds up to MAX_TIMERS one-shot timers in a row of cells, kept in
// insertion order. A transaction is accepted when start is high and busy is low;
// the result appears for exactly one cycle with done high and cannot be held off.
// Each add, and each tick on a non-empty table, sends a single token down the
// row, one cell per clock: an add stops at the cell with a matching key or at
// the first free cell (a new entry), or runs off the end (add_full). A tick
// lowers each timer it passes and stops at the first one that reaches zero;
// that cell keeps the token and a second pass copies every later entry down
// one place. A tick on an empty table sends no token, clears tick_enable and
// reports done from the idle state. busy is low in the done cycle, so the next
// start may be taken there. tick_enable and live_count track the table at all
// times and are valid with each done strobe. The table storage needs no
// clearing after reset.
module software_timer_table
    import stt_pkg::*;
#(
    parameter int MAX_TIMERS = 16,
    parameter int KEY_WIDTH  = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cmd,
    input  logic [KEY_WIDTH-1:0]                timer_key,
    input  logic [TIME_WIDTH-1:0]               timeout_ms,
    input  logic [TIME_WIDTH-1:0]               elapsed_ms,
    output logic                                done,
    output logic                                fired,
    output logic [KEY_WIDTH-1:0]                fired_key,
    output logic                                add_full,
    output logic                                tick_enable,
    output logic [$clog2(MAX_TIMERS+1)-1:0]     live_count
);

    localparam int CNT_W = $clog2(MAX_TIMERS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_TICK,
        ST_SHIFT
    } state_t;

    state_t                state_reg, state_next;
    logic [KEY_WIDTH-1:0]  key_cmd_reg, key_cmd_next;
    logic [TIME_WIDTH-1:0] value_reg, value_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  tick_on_reg, tick_on_next;
    logic                  done_reg, done_next;
    logic                  fired_reg, fired_next;
    logic [KEY_WIDTH-1:0]  fired_key_reg, fired_key_next;
    logic                  add_full_reg, add_full_next;

    cell_ctl_t             ctl;
    logic                  launch;
    logic [MAX_TIMERS:0]   tok_link;
    logic [MAX_TIMERS-1:0] tok_vec;
    logic [MAX_TIMERS-1:0] stop_vec;
    cell_stat_t            stat   [MAX_TIMERS];
    logic [KEY_WIDTH-1:0]  key_q  [MAX_TIMERS];
    logic [TIME_WIDTH-1:0] rem_q  [MAX_TIMERS];

    logic                  any_stop;
    logic                  any_fire;
    logic                  any_append;
    logic                  fall_off;
    logic [KEY_WIDTH-1:0]  hit_key;

    // ---------------------------------------------------------------
    // Cell row
    // ---------------------------------------------------------------
    assign tok_link[0] = launch;
    assign fall_off    = tok_link[MAX_TIMERS];

    always_comb
    begin
        unique case (state_reg)
            ST_ADD:   ctl.op = OP_ADD;
            ST_TICK:  ctl.op = OP_TICK;
            ST_SHIFT: ctl.op = OP_SHIFT;
            default:  ctl.op = OP_IDLE;
        endcase
        ctl.value = value_reg;
    end

    for (genvar i = 0; i < MAX_TIMERS; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0]  nb_key;
        logic [TIME_WIDTH-1:0] nb_rem;
        logic                  occupied;

        if (i < MAX_TIMERS - 1)
        begin : g_nb
            assign nb_key = key_q[i+1];
            assign nb_rem = rem_q[i+1];
        end
        else
        begin : g_last
            assign nb_key = key_q[i];
            assign nb_rem = rem_q[i];
        end

        assign occupied    = (CNT_W'(i) < count_reg);
        assign stop_vec[i] = stat[i].stop;

        stt_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .key_cmd  (key_cmd_reg),
            .occupied (occupied),
            .tok_in   (tok_link[i]),
            .nb_key   (nb_key),
            .nb_rem   (nb_rem),
            .tok_out  (tok_link[i+1]),
            .tok_q    (tok_vec[i]),
            .stat     (stat[i]),
            .key_q    (key_q[i]),
            .rem_q    (rem_q[i])
        );
    end

    // Only the token holder reports, so plain OR merges the row
    always_comb
    begin
        any_stop   = 1'b0;
        any_fire   = 1'b0;
        any_append = 1'b0;
        hit_key    = '0;
        for (int i = 0; i < MAX_TIMERS; i++)
        begin
            any_stop   = any_stop   | stat[i].stop;
            any_fire   = any_fire   | stat[i].fire;
            any_append = any_append | stat[i].append;
            hit_key    = hit_key | (stat[i].fire ? key_q[i] : '0);
        end
    end

    // ---------------------------------------------------------------
    // Command sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        key_cmd_next   = key_cmd_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        tick_on_next   = tick_on_reg;
        done_next      = 1'b0;
        fired_next     = fired_reg;
        fired_key_next = fired_key_reg;
        add_full_next  = add_full_reg;
        launch         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    fired_next     = 1'b0;
                    fired_key_next = '0;
                    add_full_next  = 1'b0;
                    key_cmd_next   = timer_key;
                    if (cmd == CMD_ADD)
                    begin
                        value_next   = (timeout_ms < MIN_TIMEOUT) ? MIN_TIMEOUT : timeout_ms;
                        tick_on_next = 1'b1;
                        launch       = 1'b1;
                        state_next   = ST_ADD;
                    end
                    else if (count_reg == '0)
                    begin
                        // empty table: tick may sleep
                        value_next   = elapsed_ms;
                        tick_on_next = 1'b0;
                        done_next    = 1'b1;
                    end
                    else
                    begin
                        value_next = elapsed_ms;
                        launch     = 1'b1;
                        state_next = ST_TICK;
                    end
                end
            end
            ST_ADD:
            begin
                if (any_stop)
                begin
                    if (any_append)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (fall_off)
                begin
                    add_full_next = 1'b1;
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (any_fire)
                begin
                    fired_next     = 1'b1;
                    fired_key_next = hit_key;
                    count_next     = count_reg - CNT_W'(1);
                    state_next     = ST_SHIFT;
                end
                else if (any_stop || fall_off)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                if (any_stop || fall_off)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_cmd_reg   <= '0;
            value_reg     <= '0;
            count_reg     <= '0;
            tick_on_reg   <= 1'b0;
            done_reg      <= 1'b0;
            fired_reg     <= 1'b0;
            fired_key_reg <= '0;
            add_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_cmd_reg   <= key_cmd_next;
            value_reg     <= value_next;
            count_reg     <= count_next;
            tick_on_reg   <= tick_on_next;
            done_reg      <= done_next;
            fired_reg     <= fired_next;
            fired_key_reg <= fired_key_next;
            add_full_reg  <= add_full_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign fired       = fired_reg;
    assign fired_key   = fired_key_reg;
    assign add_full    = add_full_reg;
    assign tick_enable = tick_on_reg;
    assign live_count  = count_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_one_token : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one cell holds the token");

    a_one_stop : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(stop_vec))
        else $error("more than one cell stopped the walk");

    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TIMERS))
        else $error("timer count above table size");

    a_idle_no_token : assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (tok_vec == '0))
        else $error("token left in the row while idle");

    a_fire_shift : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK && any_fire) |=> (state_reg == ST_SHIFT && fired_reg))
        else $error("expiry not followed by compaction");

    a_result_kind : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(fired_reg && add_full_reg))
        else $error("result reports both expiry and full table");

endmodule

FILE: tb/software_timer_table_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the software timer table: tracks the timer list, predicts and compares.
module software_timer_table_checker
    import stt_pkg::*;
#(
    parameter int MAX_TIMERS = 16,
    parameter int KEY_WIDTH  = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                cmd,
    input  logic [KEY_WIDTH-1:0]                timer_key,
    input  logic [TIME_WIDTH-1:0]               timeout_ms,
    input  logic [TIME_WIDTH-1:0]               elapsed_ms,
    input  logic                                done,
    input  logic                                fired,
    input  logic [KEY_WIDTH-1:0]                fired_key,
    input  logic                                add_full,
    input  logic                                tick_enable,
    input  logic [$clog2(MAX_TIMERS+1)-1:0]     live_count,
    output int                                  mismatches,
    output int                                  outstanding
);

    localparam int CW = $clog2(MAX_TIMERS + 1);

    typedef struct packed {
        logic                 fired;
        logic [KEY_WIDTH-1:0] fired_key;
        logic                 add_full;
        logic                 tick_enable;
        logic [CW-1:0]        live_count;
    } timer_result_t;

    // Shadow copy of the timer list, kept in insertion order
    logic [KEY_WIDTH-1:0]  slot_key  [MAX_TIMERS];
    logic [TIME_WIDTH-1:0] slot_time [MAX_TIMERS];
    int                    slot_count = 0;
    logic                  ticking    = 1'b0;

    timer_result_t         pending_results [$];

    // Applies one command to the shadow list and returns what the block must report.
    function automatic timer_result_t apply_timer_cmd(
        input logic                  op,
        input logic [KEY_WIDTH-1:0]  key,
        input logic [TIME_WIDTH-1:0] timeout,
        input logic [TIME_WIDTH-1:0] elapsed
    );
        timer_result_t         res;
        logic                  hit;
        logic                  stopped;
        logic [TIME_WIDTH-1:0] t;
        res = '0;
        if (op == CMD_ADD)
        begin
            t   = (timeout < MIN_TIMEOUT) ? MIN_TIMEOUT : timeout;
            hit = 1'b0;
            for (int i = 0; i < MAX_TIMERS; i++)
            begin
                if (!hit && i < slot_count && slot_key[i] == key)
                begin
                    slot_time[i] = t;
                    hit          = 1'b1;
                end
            end
            if (!hit)
            begin
                if (slot_count < MAX_TIMERS)
                begin
                    slot_key[slot_count]  = key;
                    slot_time[slot_count] = t;
                    slot_count++;
                end
                else
                begin
                    res.add_full = 1'b1;
                end
            end
            ticking = 1'b1;
        end
        else if (slot_count == 0)
        begin
            ticking = 1'b0;
        end
        else
        begin
            stopped = 1'b0;
            for (int i = 0; i < MAX_TIMERS; i++)
            begin
                if (!stopped && i < slot_count)
                begin
                    slot_time[i] = (slot_time[i] > elapsed) ? slot_time[i] - elapsed : '0;
                    if (slot_time[i] == '0)
                    begin
                        stopped       = 1'b1;
                        res.fired     = 1'b1;
                        res.fired_key = slot_key[i];
                        for (int j = i; j < slot_count - 1; j++)
                        begin
                            slot_key[j]  = slot_key[j+1];
                            slot_time[j] = slot_time[j+1];
                        end
                        slot_count--;
                    end
                end
            end
        end
        res.tick_enable = ticking;
        res.live_count  = CW'(slot_count);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        timer_result_t got;
        timer_result_t pred;
        if (!rst_n)
        begin
            slot_count = 0;
            ticking    = 1'b0;
            mismatches = 0;
            pending_results.delete();
        end
        else
        begin
            // retire first: a new command may be taken in the done cycle
            if (done)
            begin
                got = '{fired, fired_key, add_full, tick_enable, live_count};
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result %p", $time, got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.fired       !== want.fired       ||
                        got.fired_key   !== want.fired_key   ||
                        got.add_full    !== want.add_full    ||
                        got.tick_enable !== want.tick_enable ||
                        got.live_count  !== want.live_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $time, want, got);
                    end
                end
            end
            if (start && !busy)
            begin
                pred            = apply_timer_cmd(cmd, timer_key, timeout_ms, elapsed_ms);
                pending_results = {pending_results, pred};
            end
        end
        outstanding = pending_results.size();
    end

endmodule

FILE: tb/software_timer_table_tb.sv
`timescale 1ns / 1ps
// Testbench top for the software timer table: clock, reset, command stimulus and verdict.
module software_timer_table_tb
    import stt_pkg::*;
();

    localparam int MAX_TIMERS = 16;
    localparam int KEY_WIDTH  = 8;
    localparam int CW         = $clog2(MAX_TIMERS + 1);
    // settling wait, sized from the longest span from accept to done
    localparam int DRAIN_CYCLES = 2 * MAX_TIMERS + 4;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  cmd;
    logic [KEY_WIDTH-1:0]  timer_key;
    logic [TIME_WIDTH-1:0] timeout_ms;
    logic [TIME_WIDTH-1:0] elapsed_ms;
    logic                  done;
    logic                  fired;
    logic [KEY_WIDTH-1:0]  fired_key;
    logic                  add_full;
    logic                  tick_enable;
    logic [CW-1:0]         live_count;

    int                    mismatches;
    int                    outstanding;

    // Percent of cycles the command side holds back before offering a transaction
    int                    sender_idle_pct = 0;
    // Percent of random transactions that are adds; re-rolled every 50 transactions
    int                    add_pct = 50;

    software_timer_table #(
        .MAX_TIMERS (MAX_TIMERS),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .timer_key   (timer_key),
        .timeout_ms  (timeout_ms),
        .elapsed_ms  (elapsed_ms),
        .done        (done),
        .fired       (fired),
        .fired_key   (fired_key),
        .add_full    (add_full),
        .tick_enable (tick_enable),
        .live_count  (live_count)
    );

    software_timer_table_checker #(
        .MAX_TIMERS (MAX_TIMERS),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .timer_key   (timer_key),
        .timeout_ms  (timeout_ms),
        .elapsed_ms  (elapsed_ms),
        .done        (done),
        .fired       (fired),
        .fired_key   (fired_key),
        .add_full    (add_full),
        .tick_enable (tick_enable),
        .live_count  (live_count),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs; a clean run ends well before it
    initial
    begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Offers one transaction and returns on the edge that takes it. Idle cycles
    // are inserted before start goes high; once high, start stays up until the
    // block takes it, so busy is never sampled with start dropping mid-wait.
    // busy is read right after the edge, i.e. the value the block saw at that edge.
    task automatic issue_command(
        input logic                  op,
        input logic [KEY_WIDTH-1:0]  key,
        input logic [TIME_WIDTH-1:0] tmo,
        input logic [TIME_WIDTH-1:0] elap
    );
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= op;
        timer_key  <= key;
        timeout_ms <= tmo;
        elapsed_ms <= elap;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Random transaction. Keys mostly come from a pool a bit larger than the
    // table so updates, appends and full-table drops all show up; times are
    // mostly small so timers actually expire, with full-range values mixed in
    // to toggle every bit and to hit saturation.
    task automatic issue_random();
        logic                  op;
        logic [KEY_WIDTH-1:0]  key;
        logic [TIME_WIDTH-1:0] tmo;
        logic [TIME_WIDTH-1:0] elap;
        int                    roll;
        op   = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_TICK;
        roll = $urandom_range(0, 99);
        key  = (roll < 80) ? KEY_WIDTH'($urandom_range(0, MAX_TIMERS + 7))
                           : KEY_WIDTH'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 10)
            tmo = '0;
        else if (roll < 75)
            tmo = TIME_WIDTH'($urandom_range(1, 40));
        else
            tmo = TIME_WIDTH'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 10)
            elap = '0;
        else if (roll < 70)
            elap = TIME_WIDTH'($urandom_range(1, 15));
        else if (roll < 85)
            elap = TIME_WIDTH'($urandom_range(16, 1000));
        else
            elap = TIME_WIDTH'($urandom);
        issue_command(op, key, tmo, elap);
    endtask

    initial
    begin
        int idle_plan [3];
        int waited;
        idle_plan[0] = 25;
        idle_plan[1] = 85;
        idle_plan[2] = 0;

        start      <= 1'b0;
        cmd        <= CMD_ADD;
        timer_key  <= '0;
        timeout_ms <= '0;
        elapsed_ms <= '0;
        rst_n      <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed transactions, back to back ----
        // tick on an empty table right out of reset: ticking stays off
        issue_command(CMD_TICK, 8'h00, '0, TIME_WIDTH'($urandom));
        // zero timeout is raised to the minimum
        issue_command(CMD_ADD, 8'h00, '0, '0);
        // top key, longest timeout
        issue_command(CMD_ADD, 8'hFF, '1, '1);
        // update of an existing key keeps its slot
        issue_command(CMD_ADD, 8'h00, 32'd5, '0);
        // zero elapsed: nothing expires, nothing moves
        issue_command(CMD_TICK, 8'h00, '0, '0);
        issue_command(CMD_TICK, 8'h00, '0, 32'd3);
        // huge elapsed saturates at zero; only the first timer fires
        issue_command(CMD_TICK, 8'h00, '0, '1);
        // fill the table up to its last slot
        for (int k = 1; k < MAX_TIMERS; k++)
            issue_command(CMD_ADD, KEY_WIDTH'(k), TIME_WIDTH'(k * 3), '0);
        // new key on a full table is dropped with add_full
        issue_command(CMD_ADD, KEY_WIDTH'(MAX_TIMERS), 32'd7, '0);
        // the long-lived head entry fires and the rest compact down
        issue_command(CMD_TICK, 8'h00, '0, '1);
        // freed slot takes the previously dropped key
        issue_command(CMD_ADD, KEY_WIDTH'(MAX_TIMERS), '1, '0);

        // ---- random transactions in three idling phases ----
        for (int p = 0; p < 3; p++)
        begin
            sender_idle_pct = idle_plan[p];
            for (int n = 0; n < 200; n++)
            begin
                if (n % 50 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       add_pct = 35;
                        1:       add_pct = 55;
                        default: add_pct = 70;
                    endcase
                end
                issue_random();
            end
        end
        start <= 1'b0;

        // let every result come back, then a little more for stray strobes
        waited = 0;
        while (outstanding != 0 && waited < 20 * DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (outstanding != 0)
            $display("%0t: %0d results never arrived", $time, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
